@@ sv/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// shared sizes, codes and helpers of the bucket bump allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BUCKETS   = 16;
    localparam int BUCKET_BYTES  = 65536;
    localparam int HEADER_BYTES  = 64;
    localparam int MAX_OBJ_BYTES = 4096;

    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int FREE_W = 17;
    localparam int SIZE_W = 12;
    localparam int OFF_W  = 16;

    localparam logic [FREE_W-1:0] CAP_BYTES  = FREE_W'(BUCKET_BYTES - HEADER_BYTES);
    localparam logic [FREE_W-1:0] MAX_OBJ    = FREE_W'(MAX_OBJ_BYTES);
    localparam logic [FREE_W-1:0] BKT_BYTES  = FREE_W'(BUCKET_BYTES);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(NUM_BUCKETS);

    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_ZERO      = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_CLEARED   = 3'd4
    } status_t;

    // next free offset of a bucket follows from its free space
    function automatic logic [OFF_W-1:0] off_from_free(input logic [FREE_W-1:0] f);
        logic [FREE_W-1:0] d;
        begin
            d = BKT_BYTES - f;
            return d[OFF_W-1:0];
        end
    endfunction

endpackage

@@ sv/bba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/bba_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_alu
// shared subtract and compare unit of the allocator sequencer
// ----------------------------------------------------------------------------
module bba_alu import bba_pkg::*; (
    input  logic [FREE_W-1:0] a,
    input  logic [FREE_W-1:0] b,
    output logic [FREE_W-1:0] diff,
    output logic              ge,
    output logic              gt
);

    logic [FREE_W:0] wide;

    // one subtractor: borrow gives the order, zero result gives equality
    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[FREE_W-1:0];
    assign ge   = ~wide[FREE_W];
    assign gt   = ~wide[FREE_W] & (wide[FREE_W-1:0] != '0);

endmodule

@@ sv/bucket_bump_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_bump_allocator
// bump allocator over a pool of sixteen 64 KiB buckets
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. Release-all, zero-size and oversize
// requests answer in the cycle after acceptance; an allocation that fits in the
// current bucket answers from S_CUR. Otherwise the free space of every open
// bucket is read from the single-port bucket table, one entry per cycle, and
// the answer comes from S_DECIDE if the pool is exhausted, else from S_COMMIT.
// The scan, the size checks and the bump share one subtract/compare unit. A new
// request is taken only once the previous one is answered, and a result still
// waiting at the output holds off the next request until it is taken.
module bucket_bump_allocator import bba_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // size[11:0], zero pad
    input  logic [0:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // bucket[3:0], offset[19:4], zero pad
    output logic [3:0]  m_axis_tuser    // status[2:0], opened_new[3]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_SCAN,
        S_DECIDE,
        S_NEW,
        S_COMMIT
    } state_t;

    state_t            state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  bucket_reg, bucket_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic              opened_reg, opened_next;

    logic [CNT_W-1:0]  open_count_reg, open_count_next;
    logic [IDX_W-1:0]  cur_idx_reg, cur_idx_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              have_best_reg, have_best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [FREE_W-1:0] best_free_reg, best_free_next;
    logic [FREE_W-1:0] cur_free_reg, cur_free_next;
    logic [FREE_W-1:0] new_free_reg, new_free_next;
    logic              take_best_reg, take_best_next;
    logic [FREE_W-1:0] size_reg, size_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    logic [FREE_W-1:0] ram_wdata;
    logic [FREE_W-1:0] ram_rdata;

    logic [FREE_W-1:0] alu_a, alu_b, alu_diff;
    logic              alu_ge, alu_gt;

    logic              in_fire;
    logic              out_free;
    logic [FREE_W-1:0] in_size;
    cmd_t              in_cmd;

    bba_ram #(
        .WIDTH (FREE_W),
        .DEPTH (NUM_BUCKETS)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bba_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge),
        .gt   (alu_gt)
    );

    assign out_free      = ~m_valid_reg | m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) & out_free;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign in_size       = FREE_W'(s_axis_tdata[SIZE_W-1:0]);
    assign in_cmd        = cmd_t'(s_axis_tuser[0]);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, offset_reg, bucket_reg};
    assign m_axis_tuser  = {opened_reg, status_reg};

    always_comb
    begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg & ~m_axis_tready;
        status_next     = status_reg;
        bucket_next     = bucket_reg;
        offset_next     = offset_reg;
        opened_next     = opened_reg;
        open_count_next = open_count_reg;
        cur_idx_next    = cur_idx_reg;
        cur_valid_next  = cur_valid_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        have_best_next  = have_best_reg;
        best_idx_next   = best_idx_reg;
        best_free_next  = best_free_reg;
        cur_free_next   = cur_free_reg;
        new_free_next   = new_free_reg;
        take_best_next  = take_best_reg;
        size_next       = size_reg;

        ram_we    = 1'b0;
        ram_addr  = cur_idx_reg;
        ram_wdata = alu_diff;
        alu_a     = size_reg;
        alu_b     = size_reg;

        case (state_reg)
            S_IDLE:
            begin
                // current bucket is read ahead so its space is there next cycle
                alu_a = in_size;
                alu_b = MAX_OBJ;
                if (in_fire)
                begin
                    size_next   = in_size;
                    bucket_next = '0;
                    offset_next = '0;
                    opened_next = 1'b0;
                    if (in_cmd == CMD_RELEASE)
                    begin
                        open_count_next = '0;
                        cur_idx_next    = '0;
                        cur_valid_next  = 1'b0;
                        status_next     = ST_CLEARED;
                        m_valid_next    = 1'b1;
                    end
                    else if (alu_ge || (in_size > CAP_BYTES))
                    begin
                        status_next  = ST_TOO_LARGE;
                        m_valid_next = 1'b1;
                    end
                    else if (in_size == '0)
                    begin
                        status_next  = ST_ZERO;
                        m_valid_next = 1'b1;
                    end
                    else if (cur_valid_reg)
                    begin
                        state_next = S_CUR;
                    end
                    else
                    begin
                        scan_idx_next  = '0;
                        have_best_next = 1'b0;
                        best_free_next = '0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_CUR:
            begin
                alu_a = ram_rdata;
                alu_b = size_reg;
                if (alu_ge)
                begin
                    ram_we       = 1'b1;
                    status_next  = ST_OK;
                    bucket_next  = cur_idx_reg;
                    offset_next  = off_from_free(ram_rdata);
                    opened_next  = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cur_free_next  = ram_rdata;
                    scan_idx_next  = '0;
                    have_best_next = 1'b0;
                    best_free_next = '0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, judge the entry read last cycle
                ram_addr = scan_idx_reg[IDX_W-1:0];
                alu_a    = ram_rdata;
                alu_b    = best_free_reg;
                if (scan_idx_reg < open_count_reg)
                begin
                    scan_idx_next   = scan_idx_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                if (pend_valid_reg)
                begin
                    if ((ram_rdata != '0) && alu_ge)
                    begin
                        best_idx_next  = pend_idx_reg;
                        best_free_next = ram_rdata;
                        have_best_next = 1'b1;
                    end
                end
                else if (scan_idx_reg == open_count_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                alu_a    = best_free_reg;
                alu_b    = size_reg;
                ram_addr = best_idx_reg;
                if (have_best_reg && !(cur_valid_reg && (best_idx_reg == cur_idx_reg))
                    && alu_gt)
                begin
                    ram_we         = 1'b1;
                    new_free_next  = alu_diff;
                    take_best_next = 1'b1;
                    state_next     = S_COMMIT;
                end
                else if (open_count_reg == FULL_COUNT)
                begin
                    status_next  = ST_EXHAUSTED;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end

            S_NEW:
            begin
                alu_a          = CAP_BYTES;
                alu_b          = size_reg;
                ram_addr       = open_count_reg[IDX_W-1:0];
                ram_we         = 1'b1;
                new_free_next  = alu_diff;
                take_best_next = 1'b0;
                state_next     = S_COMMIT;
            end

            S_COMMIT:
            begin
                alu_a          = new_free_reg;
                alu_b          = take_best_reg ? cur_free_reg : best_free_reg;
                cur_valid_next = 1'b1;
                status_next    = ST_OK;
                m_valid_next   = 1'b1;
                state_next     = S_IDLE;
                if (take_best_reg)
                begin
                    if (!cur_valid_reg || alu_gt)
                    begin
                        cur_idx_next = best_idx_reg;
                    end
                    bucket_next = best_idx_reg;
                    offset_next = off_from_free(best_free_reg);
                    opened_next = 1'b0;
                end
                else
                begin
                    // ties stay with the scanned bucket
                    cur_idx_next    = (!have_best_reg || alu_gt) ?
                                      open_count_reg[IDX_W-1:0] : best_idx_reg;
                    open_count_next = open_count_reg + 1'b1;
                    bucket_next     = open_count_reg[IDX_W-1:0];
                    offset_next     = off_from_free(CAP_BYTES);
                    opened_next     = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            status_reg     <= ST_OK;
            bucket_reg     <= '0;
            offset_reg     <= '0;
            opened_reg     <= 1'b0;
            open_count_reg <= '0;
            cur_idx_reg    <= '0;
            cur_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            have_best_reg  <= 1'b0;
            best_idx_reg   <= '0;
            best_free_reg  <= '0;
            cur_free_reg   <= '0;
            new_free_reg   <= '0;
            take_best_reg  <= 1'b0;
            size_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            status_reg     <= status_next;
            bucket_reg     <= bucket_next;
            offset_reg     <= offset_next;
            opened_reg     <= opened_next;
            open_count_reg <= open_count_next;
            cur_idx_reg    <= cur_idx_next;
            cur_valid_reg  <= cur_valid_next;
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            have_best_reg  <= have_best_next;
            best_idx_reg   <= best_idx_next;
            best_free_reg  <= best_free_next;
            cur_free_reg   <= cur_free_next;
            new_free_reg   <= new_free_next;
            take_best_reg  <= take_best_next;
            size_reg       <= size_next;
        end
    end

    // pool never holds more buckets than exist
    assert property (@(posedge clk) disable iff (!rst_n)
        open_count_reg <= FULL_COUNT)
        else $error("open bucket count beyond pool size");

    // current bucket is always one of the open buckets
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (CNT_W'(cur_idx_reg) < open_count_reg))
        else $error("current bucket not open");

    // error and clear answers carry no location
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (status_reg != ST_OK)) |->
            (bucket_reg == '0) && (offset_reg == '0) && !opened_reg)
        else $error("non-ok answer with location fields set");

    // a freshly opened bucket becomes part of the pool in the same step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && !take_best_reg) |=>
            (open_count_reg == $past(open_count_reg) + 1'b1) && cur_valid_reg)
        else $error("new bucket not counted");

    // no request taken while a scan is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !s_axis_tready)
        else $error("request accepted mid scan");

endmodule
